[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the stack core modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    `ASSERT_AT(label, clk, rst_n, (ante) |-> (cons))

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `ASSERT_AT(label, clk, rst_n, (ante) |=> (cons))

`endif

[hw/rtl/swrd_pkg.sv]
// ----------------------------------------------------------------------------
// swrd_pkg
// Types, codes and defaults shared by the stack-with-range-delete modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swrd_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic [6:0]         entry_count;
        logic [6:0]         removed_count;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic res_load;
        logic pop_load;
        logic del_step;
        logic del_finish;
    } t_dp_ctl;

    typedef struct packed {
        logic empty;
        logic del_done;
    } t_dp_stat;

endpackage

`default_nettype wire

[hw/rtl/swrd_dpath.sv]
// ----------------------------------------------------------------------------
// swrd_dpath
// Entry memory, count, delete-range walk pointers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swrd_dpath #(
    parameter int DEPTH = swrd_pkg::DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire swrd_pkg::t_in_item  i_in_data,
    input  wire swrd_pkg::t_dp_ctl   i_ctl,
    output swrd_pkg::t_dp_stat       o_stat,
    output swrd_pkg::t_out_item      o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic signed [31:0] mem [DEPTH];

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_rd;
    logic [CW-1:0]      r_wr;
    logic [CW-1:0]      r_removed;
    logic               r_rvalid;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic signed [31:0] r_rdata;
    swrd_pkg::t_out_item r_out;

    logic               s_full;
    logic               s_empty;
    logic               s_rd_more;
    logic               s_in_range;
    logic [CW-1:0]      s_count_dec;
    logic [AW-1:0]      s_rd_addr;
    logic               s_we;
    logic [AW-1:0]      s_waddr;
    logic signed [31:0] s_wdata;
    logic               s_is_push;
    logic               s_is_pop;
    logic               s_is_del;
    swrd_pkg::t_out_item n_out;

    assign s_full      = (r_count == DEPTH_C);
    assign s_empty     = (r_count == '0);
    assign s_rd_more   = (r_rd < r_count);
    assign s_in_range  = (r_lo <= r_rdata) && (r_rdata <= r_hi);
    assign s_count_dec = r_count - 1'b1;
    assign s_is_push   = (i_in_data.command == swrd_pkg::CMD_PUSH);
    assign s_is_pop    = (i_in_data.command == swrd_pkg::CMD_POP);
    assign s_is_del    = (i_in_data.command == swrd_pkg::CMD_DEL);

    assign o_stat.empty    = s_empty;
    assign o_stat.del_done = !s_rd_more && !r_rvalid;
    assign o_out_data      = r_out;

    always_comb begin
        s_rd_addr = r_rd[AW-1:0];
        if (i_ctl.accept) begin
            s_rd_addr = s_count_dec[AW-1:0];
        end
    end

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_wr[AW-1:0];
        s_wdata = r_rdata;
        if (i_ctl.accept && s_is_push && !s_full) begin
            s_we    = 1'b1;
            s_waddr = r_count[AW-1:0];
            s_wdata = i_in_data.value;
        end else if (i_ctl.del_step && r_rvalid && !s_in_range) begin
            s_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem[s_waddr] <= s_wdata;
        end
        r_rdata <= mem[s_rd_addr];
        if (i_ctl.accept && s_is_del) begin
            r_lo <= i_in_data.range_low;
            r_hi <= i_in_data.range_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_removed <= '0;
            r_rvalid  <= 1'b0;
        end else begin
            if (i_ctl.accept) begin
                if (s_is_push && !s_full) begin
                    r_count <= r_count + 1'b1;
                end else if (s_is_pop && !s_empty) begin
                    r_count <= s_count_dec;
                end
                if (s_is_del) begin
                    r_rd      <= '0;
                    r_wr      <= '0;
                    r_removed <= '0;
                    r_rvalid  <= 1'b0;
                end
            end
            if (i_ctl.del_step) begin
                if (s_rd_more) begin
                    r_rd <= r_rd + 1'b1;
                end
                r_rvalid <= s_rd_more;
                if (r_rvalid) begin
                    if (s_in_range) begin
                        r_removed <= r_removed + 1'b1;
                    end else begin
                        r_wr <= r_wr + 1'b1;
                    end
                end
            end
            if (i_ctl.del_finish) begin
                r_count <= r_wr;
            end
        end
    end

    always_comb begin
        n_out.popped_value  = '0;
        n_out.status        = swrd_pkg::STAT_OK;
        n_out.entry_count   = 7'(r_count);
        n_out.removed_count = '0;
        if (i_ctl.accept) begin
            if (s_is_push) begin
                if (s_full) begin
                    n_out.status = swrd_pkg::STAT_FULL;
                end else begin
                    n_out.entry_count = 7'(r_count + 1'b1);
                end
            end else if (s_is_pop) begin
                n_out.status = swrd_pkg::STAT_EMPTY;
            end
        end else if (i_ctl.pop_load) begin
            n_out.popped_value = r_rdata;
        end else if (i_ctl.del_finish) begin
            n_out.entry_count   = 7'(r_wr);
            n_out.removed_count = 7'(r_removed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_out <= n_out;
        end
    end

    `ASSERT_AT(a_wr_behind_rd, i_clk, i_rst_n, (r_wr <= r_rd) && (r_count <= DEPTH_C))
    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_ctl.accept && s_is_push && !s_full, r_count == $past(r_count) + 1'b1)
    `ASSERT_IMPLIES(a_del_balance, i_clk, i_rst_n, i_ctl.del_finish, r_wr + r_removed == r_count)

endmodule

`default_nettype wire

[hw/rtl/swrd_ctrl.sv]
// ----------------------------------------------------------------------------
// swrd_ctrl
// Command sequencer: handshakes, pop read wait and delete-range walk.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swrd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_command,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire swrd_pkg::t_dp_stat i_stat,
    output swrd_pkg::t_dp_ctl       o_ctl
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_DEL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   s_accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign s_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    o_ctl.accept = 1'b1;
                    unique case (i_command)
                        swrd_pkg::CMD_POP: begin
                            if (i_stat.empty) begin
                                o_ctl.res_load = 1'b1;
                            end else begin
                                n_state = ST_POP;
                            end
                        end
                        swrd_pkg::CMD_DEL: begin
                            n_state = ST_DEL;
                        end
                        default: begin
                            o_ctl.res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                o_ctl.pop_load = 1'b1;
                o_ctl.res_load = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_DEL: begin
                if (i_stat.del_done) begin
                    o_ctl.del_finish = 1'b1;
                    o_ctl.res_load   = 1'b1;
                    n_state          = ST_IDLE;
                end else begin
                    o_ctl.del_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_NEXT(a_pop_waits, i_clk, i_rst_n, s_accept && (i_command == swrd_pkg::CMD_POP) && !i_stat.empty, r_state == ST_POP)

endmodule

`default_nettype wire

[hw/rtl/stack_with_range_delete_core.sv]
// ----------------------------------------------------------------------------
// stack_with_range_delete_core
// Bounded LIFO of signed 32-bit values with push, pop and delete-range.
// ----------------------------------------------------------------------------
// Each command returns one result item with the new count. Push, an empty
// pop and the unused command code finish in the accept cycle; a pop passes
// through ST_POP for the registered read of the top entry; delete-range
// passes through ST_DEL, walking the stored entries through the single
// read port of the entry memory and writing the kept ones back down
// through its write port. One command is in work at a time; the next
// item is taken as soon as the result register is free or being drained. No
// clearing pass follows reset: entries above the count are never used.
`default_nettype none

module stack_with_range_delete_core #(
    parameter int DEPTH = swrd_pkg::DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire swrd_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output swrd_pkg::t_out_item      o_out_data
);

    swrd_pkg::t_dp_ctl  s_ctl;
    swrd_pkg::t_dp_stat s_stat;

    swrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_in_data.command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (s_stat),
        .o_ctl       (s_ctl)
    );

    swrd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_ctl      (s_ctl),
        .o_stat     (s_stat),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
